>>> rtl/assert_macros.svh
// Assertion macros shared by the sliding-window energy averager RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define SWEA_ASSERT(LABEL, CLK, RSTN, EXPR) \
  LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (EXPR)) \
    else $error("assertion failed");

// Same-cycle implication.
`define SWEA_ASSERT_IMP(LABEL, CLK, RSTN, ANTE, CONS) \
  LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
    else $error("assertion failed");

`endif

>>> rtl/swea_pkg.sv
// Shared types and constants of the sliding-window energy averager.
`default_nettype none
package swea_pkg;

  localparam int OUT_W       = 32;  // mean_energy width
  localparam int CFG_DW      = 32;  // config data width
  localparam int WIN_RESET   = 64;  // window_len after reset
  localparam int FIFO_DEPTH  = 4;   // front-to-back queue depth
  localparam int DIV_STEPS   = 4;   // quotient bits per divider cycle

  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LEN = 1'b0;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_sts_t;

  typedef struct packed {
    logic start;
    logic ack;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage
`default_nettype wire

>>> rtl/swea_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module swea_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/swea_fifo.sv
// Short queue of energies between the front and the back.
`default_nettype none
`include "assert_macros.svh"
module swea_fifo #(
  parameter int WIDTH = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire logic [WIDTH-1:0]    push_data,
  input  wire logic                pop,
  output logic      [WIDTH-1:0]    pop_data,
  output swea_pkg::fifo_sts_t      sts
);

  localparam int PW = $clog2(swea_pkg::FIFO_DEPTH);
  localparam int CW = $clog2(swea_pkg::FIFO_DEPTH + 1);

  logic [WIDTH-1:0] mem_r [swea_pkg::FIFO_DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign pop_data  = mem_r[rd_ptr_r];
  assign sts.full  = (count_r == CW'(swea_pkg::FIFO_DEPTH));
  assign sts.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(swea_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(swea_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `SWEA_ASSERT(a_fifo_no_overflow, clk, rst_n, !(push && sts.full))
  `SWEA_ASSERT(a_fifo_no_underflow, clk, rst_n, !(pop && sts.empty))

endmodule
`default_nettype wire

>>> rtl/swea_front.sv
// Front end: accepts samples, squares I and Q, pushes energies to the queue.
`default_nettype none
module swea_front #(
  parameter int SAMPLE_BITS = 16,
  localparam int E_W = 2 * SAMPLE_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_i,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_q,
  input  wire logic                          fifo_full,
  output logic                               push,
  output logic             [E_W-1:0]         push_data
);

  logic                  v_r;
  logic                  adv;
  logic signed [E_W-1:0] sq_i_r, sq_q_r;

  // squares are never negative and their sum stays below 2^E_W
  assign adv       = !v_r || !fifo_full;
  assign in_stall  = !adv;
  assign push      = v_r && !fifo_full;
  assign push_data = $unsigned(sq_i_r) + $unsigned(sq_q_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      sq_i_r <= in_sample_i * in_sample_i;
      sq_q_r <= in_sample_q * in_sample_q;
    end
  end

endmodule
`default_nettype wire

>>> rtl/swea_div.sv
// Iterative restoring divider, several quotient bits per cycle.
`default_nettype none
module swea_div #(
  parameter int DVD_W = 42,
  parameter int DVS_W = 11
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire swea_pkg::div_ctl_t ctl,
  input  wire logic [DVD_W-1:0]   dividend,
  input  wire logic [DVS_W-1:0]   divisor,
  output swea_pkg::div_sts_t      sts,
  output logic      [DVD_W-1:0]   quotient
);

  localparam int ITER  = (DVD_W + swea_pkg::DIV_STEPS - 1) / swea_pkg::DIV_STEPS;
  localparam int PAD_W = ITER * swea_pkg::DIV_STEPS;
  localparam int CW    = $clog2(ITER + 1);

  logic [PAD_W-1:0] dvd_r, dvd_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r;

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = dvd_r[DVD_W-1:0];

  // quotient bits shift in at the bottom as dividend bits leave the top
  always_comb begin
    logic [DVS_W:0] t;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    for (int k = 0; k < swea_pkg::DIV_STEPS; k++) begin
      t       = {rem_nxt, dvd_nxt[PAD_W-1]};
      dvd_nxt = {dvd_nxt[PAD_W-2:0], 1'b0};
      if (t >= {1'b0, dvs_r}) begin
        t          = t - {1'b0, dvs_r};
        dvd_nxt[0] = 1'b1;
      end
      rem_nxt = t[DVS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ctl.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(ITER);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else if (ctl.ack) begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dvd_r <= PAD_W'(dividend);
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/swea_back.sv
// Back end: window sum update over the delay line, mean division, output word.
`default_nettype none
`include "assert_macros.svh"
module swea_back #(
  parameter int MAX_WINDOW  = 1024,
  parameter int SAMPLE_BITS = 16,
  localparam int E_W   = 2 * SAMPLE_BITS,
  localparam int LW    = $clog2(MAX_WINDOW + 1),
  localparam int AW    = $clog2(MAX_WINDOW),
  localparam int SUM_W = E_W + $clog2(MAX_WINDOW)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [LW-1:0]                len,
  input  wire logic                         clr,
  input  wire swea_pkg::fifo_sts_t          fifo_sts,
  input  wire logic [E_W-1:0]               pop_data,
  output logic                              pop,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [swea_pkg::OUT_W-1:0]        out_mean_energy
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_UPD  = 2'd1;
  localparam logic [1:0] B_LOAD = 2'd2;
  localparam logic [1:0] B_WAIT = 2'd3;

  localparam int LX   = LW + 1;
  localparam int QX_W = (SUM_W > swea_pkg::OUT_W) ? SUM_W : swea_pkg::OUT_W;

  logic [1:0]                 state_r, state_nxt;
  logic [E_W-1:0]             e_r, e_nxt;
  logic                       filling_r, filling_nxt;
  logic [LW-1:0]              fill_r, fill_nxt, fill_inc;
  logic [SUM_W-1:0]           sum_r, sum_nxt;
  logic [AW-1:0]              wp_r, wp_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [swea_pkg::OUT_W-1:0] mean_r, mean_nxt;

  logic [LX-1:0]    wp_x, len_x, rd_x;
  logic [AW-1:0]    raddr;
  logic             re, we;
  logic [E_W-1:0]   rdata;
  logic [SUM_W-1:0] quot;
  logic [QX_W-1:0]  quot_x;

  swea_pkg::div_ctl_t div_ctl;
  swea_pkg::div_sts_t div_sts;

  assign out_valid       = out_valid_r;
  assign out_mean_energy = mean_r;
  assign fill_inc        = fill_r + LW'(1);
  assign quot_x          = QX_W'(quot);

  // oldest energy still in the window sits len entries behind the write pointer
  assign wp_x  = LX'(wp_r);
  assign len_x = LX'(len);
  assign rd_x  = (wp_x >= len_x) ? (wp_x - len_x) : (wp_x + LX'(MAX_WINDOW) - len_x);
  assign raddr = rd_x[AW-1:0];

  swea_ram #(
    .WIDTH(E_W),
    .DEPTH(MAX_WINDOW)
  ) u_hist (
    .clk  (clk),
    .we   (we),
    .waddr(wp_r),
    .wdata(e_r),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  swea_div #(
    .DVD_W(SUM_W),
    .DVS_W(LW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (div_ctl),
    .dividend(sum_r),
    .divisor (len),
    .sts     (div_sts),
    .quotient(quot)
  );

  always_comb begin
    state_nxt     = state_r;
    e_nxt         = e_r;
    filling_nxt   = filling_r;
    fill_nxt      = fill_r;
    sum_nxt       = sum_r;
    wp_nxt        = wp_r;
    out_valid_nxt = out_valid_r;
    mean_nxt      = mean_r;
    pop           = 1'b0;
    re            = 1'b0;
    we            = 1'b0;
    div_ctl.start = 1'b0;
    div_ctl.ack   = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      B_IDLE: begin
        if (!fifo_sts.empty) begin
          pop         = 1'b1;
          re          = 1'b1;
          e_nxt       = pop_data;
          filling_nxt = (fill_r < len);
          state_nxt   = B_UPD;
        end
      end
      B_UPD: begin
        we     = 1'b1;
        wp_nxt = (wp_r == AW'(MAX_WINDOW - 1)) ? '0 : wp_r + AW'(1);
        if (filling_r) begin
          sum_nxt   = sum_r + SUM_W'(e_r);
          fill_nxt  = fill_inc;
          state_nxt = (fill_inc == len) ? B_LOAD : B_IDLE;
        end else begin
          sum_nxt   = sum_r + SUM_W'(e_r) - SUM_W'(rdata);
          state_nxt = B_LOAD;
        end
      end
      B_LOAD: begin
        div_ctl.start = 1'b1;
        state_nxt     = B_WAIT;
      end
      B_WAIT: begin
        if (div_sts.done && (!out_valid_r || !out_stall)) begin
          div_ctl.ack   = 1'b1;
          mean_nxt      = quot_x[swea_pkg::OUT_W-1:0];
          out_valid_nxt = 1'b1;
          state_nxt     = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase

    if (clr) begin
      fill_nxt = '0;
      sum_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      fill_r      <= '0;
      sum_r       <= '0;
      wp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      wp_r        <= wp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r       <= e_nxt;
    filling_r <= filling_nxt;
    mean_r    <= mean_nxt;
  end

  `SWEA_ASSERT(a_fill_within_len, clk, rst_n, fill_r <= len)
  `SWEA_ASSERT_IMP(a_word_from_divider, clk, rst_n, $rose(out_valid_r), $past(state_r == B_WAIT))

endmodule
`default_nettype wire

>>> rtl/sliding_window_energy_average.sv
// Top level of the sliding-window energy averager: config register, front, queue, back.
// A sample that yields a word goes through the 4-bit-per-cycle divider (11 iterations for the
//   default 42-bit window sum) before the back takes the next energy from the queue.
// Reset (rst_n low, synchronous): window_len to 64, fill count, window sum and write
//   pointer to zero; the energy history RAM is not cleared and needs no clearing pass.
`default_nettype none
module sliding_window_energy_average #(
  parameter int MAX_WINDOW  = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // sample input channel
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]          in_sample_i,
  input  wire logic signed [SAMPLE_BITS-1:0]          in_sample_q,
  // mean energy output channel
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic             [swea_pkg::OUT_W-1:0]      out_mean_energy,
  // APB-style config port
  input  wire logic                                   cfg_psel,
  input  wire logic                                   cfg_penable,
  input  wire logic                                   cfg_pwrite,
  input  wire logic        [swea_pkg::REG_IDX_W+1:0]  cfg_paddr,
  input  wire logic        [swea_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic             [swea_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                                        cfg_pready
);

  localparam int E_W = 2 * SAMPLE_BITS;
  localparam int LW  = $clog2(MAX_WINDOW + 1);
  // reset length never exceeds the delay line
  localparam int LEN_RST = (swea_pkg::WIN_RESET > MAX_WINDOW) ? MAX_WINDOW
                                                              : swea_pkg::WIN_RESET;

  logic [LW-1:0]  len_r, len_nxt;
  logic           cfg_wr;
  logic           len_wr;
  logic           push, pop;
  logic [E_W-1:0] push_data, pop_data;

  swea_pkg::fifo_sts_t fifo_sts;

  // --- configuration ---
  // one register: window_len at byte address 0; zero means 1, beyond the delay line clamps
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign len_wr     = cfg_wr &&
                      (cfg_paddr[swea_pkg::REG_IDX_W+1:2] == swea_pkg::REG_WINDOW_LEN);

  always_comb begin
    if (cfg_pwdata == '0) begin
      len_nxt = LW'(1);
    end else if (cfg_pwdata > swea_pkg::CFG_DW'(MAX_WINDOW)) begin
      len_nxt = LW'(MAX_WINDOW);
    end else begin
      len_nxt = cfg_pwdata[LW-1:0];
    end
  end

  always_comb begin
    if (cfg_paddr[swea_pkg::REG_IDX_W+1:2] == swea_pkg::REG_WINDOW_LEN) begin
      cfg_prdata = swea_pkg::CFG_DW'(len_r);
    end else begin
      cfg_prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LW'(LEN_RST);
    end else if (len_wr) begin
      len_r <= len_nxt;
    end
  end

  // --- front: takes a word per cycle while the queue is not full, squares I and Q ---
  swea_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_sample_i(in_sample_i),
    .in_sample_q(in_sample_q),
    .fifo_full  (fifo_sts.full),
    .push       (push),
    .push_data  (push_data)
  );

  // --- energy queue: decouples front from the iterative back ---
  swea_fifo #(
    .WIDTH(E_W)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .pop_data (pop_data),
    .sts      (fifo_sts)
  );

  // --- back: window sum, delay line RAM, divider, output register ---
  // a window_len write restarts the fill count and clears the sum
  swea_back #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .len            (len_r),
    .clr            (len_wr),
    .fifo_sts       (fifo_sts),
    .pop_data       (pop_data),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_mean_energy(out_mean_energy)
  );

endmodule
`default_nettype wire

>>> verif/sliding_window_energy_average_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the sliding-window energy averager: directed table, then random phases.
module sliding_window_energy_average_tb;

  localparam int MAX_WIN = 1024;
  localparam int SBITS   = 16;
  localparam int AW      = swea_pkg::REG_IDX_W + 2;

  // byte addresses: the window register, and the first index past the map
  localparam logic [AW-1:0] ADDR_WINDOW_LEN = {swea_pkg::REG_WINDOW_LEN, 2'b00};
  localparam logic [AW-1:0] ADDR_UNMAPPED   = {~swea_pkg::REG_WINDOW_LEN, 2'b00};

  localparam int SETTLE_CYCLES = 48;      // pipeline latency plus queued fill words
  localparam int HOLD_AT       = 70;      // mean word after which the sink backs off
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int unsigned RAND_WIN = 32'hFFFF_FFFF;  // phase marker: draw a window length
  localparam int unsigned FULL_MAX = 64;  // widest window that is filled to the end

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SBITS-1:0] in_sample_i = '0;
  logic signed [SBITS-1:0] in_sample_q = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [swea_pkg::OUT_W-1:0] out_mean_energy;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [AW-1:0] cfg_paddr = '0;
  logic [swea_pkg::CFG_DW-1:0] cfg_pwdata = '0;
  logic [swea_pkg::CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  sliding_window_energy_average dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_i     (in_sample_i),
    .in_sample_q     (in_sample_q),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_mean_energy (out_mean_energy),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Energy window model: own copy of the delay line, running sum, fill count,
  // write pointer and window length. History entries start unknown; the fill
  // rule guarantees none is read before it is written.
  // ---------------------------------------------------------------------------
  logic [31:0]   energy_hist [MAX_WIN];
  logic [41:0]   win_sum  = '0;
  int unsigned   fill_cnt = 0;
  int unsigned   win_len  = swea_pkg::WIN_RESET;
  logic [9:0]    wr_ptr   = '0;

  logic [swea_pkg::OUT_W-1:0] mean_q [$];   // mean words still owed by the block

  int errors     = 0;
  int words_in   = 0;
  int words_out  = 0;
  int cfg_writes = 0;
  int cycle_cnt  = 0;
  bit tx_quiet   = 1'b0;
  bit rx_quiet   = 1'b0;

  // Advance the model by one sample; returns 1 when the window is full and a
  // mean word is due.
  function automatic bit predict_mean(input logic signed [SBITS-1:0] si,
                                      input logic signed [SBITS-1:0] sq,
                                      output logic [swea_pkg::OUT_W-1:0] mean);
    logic [31:0] e;
    logic [9:0]  rd;
    // exact magnitude squared; (-32768)^2 * 2 = 2^31 still fits 32 bits unsigned
    e = 32'(longint'(si) * longint'(si) + longint'(sq) * longint'(sq));
    if (fill_cnt < win_len) begin
      win_sum = win_sum + e;
      fill_cnt++;
    end else begin
      // oldest entry sits win_len slots behind the write pointer, mod 1024
      rd = wr_ptr - 10'(win_len);
      win_sum = win_sum + e - energy_hist[rd];
    end
    energy_hist[wr_ptr] = e;
    wr_ptr = wr_ptr + 1'b1;
    mean = swea_pkg::OUT_W'(win_sum / win_len);
    return fill_cnt >= win_len;
  endfunction

  // Register write as the block sees it: unmapped index ignored, window length
  // clamped to 1..MAX_WIN, fill and sum cleared; history and pointer kept.
  function automatic void apply_cfg(input logic [AW-1:0] addr,
                                    input logic [swea_pkg::CFG_DW-1:0] data);
    if (addr != ADDR_WINDOW_LEN) return;
    if (data == 0) win_len = 1;
    else if (data > MAX_WIN) win_len = MAX_WIN;
    else win_len = data;
    fill_cnt = 0;
    win_sum  = '0;
  endfunction

  // Idle cycles for the next word; each side flips now and then into a
  // stretch with no idling at all.
  function automatic int draw_idle(inout bit quiet);
    if ($urandom_range(0, 39) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, 13);
  endfunction

  // Component mix: hard extremes, values near zero and full-range noise.
  function automatic logic signed [SBITS-1:0] rand_comp();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'($urandom_range(0, 16)) - 16'sd8;
      default: return 16'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sample driver. Called at a falling edge; returns at the falling edge after
  // the word is taken, with in_valid still high so a back-to-back word needs no
  // second assignment in the same step.
  // ---------------------------------------------------------------------------
  task automatic send_sample(input logic signed [SBITS-1:0] si,
                             input logic signed [SBITS-1:0] sq,
                             input int gap,
                             input bit fixed,
                             input logic [swea_pkg::OUT_W-1:0] fixed_mean);
    logic [swea_pkg::OUT_W-1:0] m;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_sample_i <= si;
    in_sample_q <= sq;
    do @(posedge clk); while (in_stall !== 1'b0);
    words_in++;
    // directed rows with a typed-in mean override the model's value
    if (predict_mean(si, sq, m)) mean_q.push_back(fixed ? fixed_mean : m);
    @(negedge clk);
  endtask

  // Idle the input, let every owed word come out, then wait out the pipeline
  // so fill-only samples still in flight land before a register write.
  task automatic settle();
    in_valid <= 1'b0;
    while (mean_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // APB write: setup, then access until pready. Called at a falling edge.
  task automatic cfg_write(input logic [AW-1:0] addr,
                           input logic [swea_pkg::CFG_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    apply_cfg(addr, data);
    cfg_writes++;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // APB read with a compare of prdata. Called at a falling edge.
  task automatic cfg_read_check(input logic [AW-1:0] addr,
                                input logic [swea_pkg::CFG_DW-1:0] want);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_paddr   <= addr;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    if (cfg_prdata !== want) begin
      errors++;
      if (errors <= 10)
        $display("window_len read mismatch: expected %0d got %0d", want, cfg_prdata);
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Directed table. A row may carry a register write that goes ahead of its
  // sample. 'fixed' rows carry a mean that can be read off by hand; the rest
  // are checked against the model.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic             wr;
    logic [AW-1:0]    addr;
    logic [31:0]      wdata;
    logic [SBITS-1:0] si;
    logic [SBITS-1:0] sq;
    logic             fixed;
    logic [31:0]      mean;
  } stim_row_t;

  localparam int DIR_N = 19;
  localparam logic [AW-1:0] WL = ADDR_WINDOW_LEN;

  stim_row_t dir_tab [DIR_N] = '{
    // reset window of 64: two samples, no word
    '{1'b0, WL, 32'd0, 16'h8000, 16'h7FFF, 1'b0, 32'd0},
    '{1'b0, WL, 32'd0, 16'h0000, 16'h0000, 1'b0, 32'd0},
    // window 1: the mean is the sample energy itself
    '{1'b1, WL, 32'd1, 16'h8000, 16'h8000, 1'b1, 32'h8000_0000},
    '{1'b0, WL, 32'd0, 16'h7FFF, 16'h7FFF, 1'b1, 32'd2147352578},
    '{1'b0, WL, 32'd0, 16'h0000, 16'h0000, 1'b1, 32'd0},
    '{1'b0, WL, 32'd0, 16'h8000, 16'h0000, 1'b1, 32'h4000_0000},
    '{1'b0, WL, 32'd0, 16'h0000, 16'h8000, 1'b1, 32'h4000_0000},
    '{1'b0, WL, 32'd0, 16'hFFFF, 16'h0001, 1'b1, 32'd2},
    '{1'b0, WL, 32'd0, 16'h7FFF, 16'h8000, 1'b1, 32'd2147418113},
    // zero length is taken as one
    '{1'b1, WL, 32'd0, 16'h0003, 16'h0004, 1'b1, 32'd25},
    // window 2: 2^32 sum halves back to 2^31, then truncation of 1/2
    '{1'b1, WL, 32'd2, 16'h8000, 16'h8000, 1'b0, 32'd0},
    '{1'b0, WL, 32'd0, 16'h8000, 16'h8000, 1'b1, 32'h8000_0000},
    '{1'b0, WL, 32'd0, 16'h0000, 16'h0000, 1'b1, 32'h4000_0000},
    '{1'b0, WL, 32'd0, 16'h0001, 16'h0000, 1'b1, 32'd0},
    // unmapped index: ignored, the window stays full
    '{1'b1, ADDR_UNMAPPED, 32'd5, 16'h0000, 16'h0003, 1'b0, 32'd0},
    // window 3 refill
    '{1'b1, WL, 32'd3, 16'h0005, 16'h0005, 1'b0, 32'd0},
    '{1'b0, WL, 32'd0, 16'hFFF9, 16'h0002, 1'b0, 32'd0},
    '{1'b0, WL, 32'd0, 16'h0064, 16'hFF9C, 1'b0, 32'd0},
    '{1'b0, WL, 32'd0, 16'h7FFF, 16'hFFFF, 1'b0, 32'd0}
  };

  // Random phases: reset value, both extremes, clamp of an oversize value,
  // zero, and drawn small windows so most words come out quickly. Every
  // written length is read back; the widest windows only get a partial fill.
  localparam int N_PHASE = 13;
  int unsigned phase_win [N_PHASE] = '{
    swea_pkg::WIN_RESET, 1, 2, MAX_WIN, 7, RAND_WIN, RAND_WIN, 2047, 0, 33,
    RAND_WIN, RAND_WIN, RAND_WIN
  };

  initial begin : stimulus
    int unsigned wl;
    int unsigned eff;
    int n;
    int gap;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[r]) begin
      if (dir_tab[r].wr) begin
        settle();
        cfg_write(dir_tab[r].addr, dir_tab[r].wdata);
      end
      gap = draw_idle(tx_quiet);
      send_sample(dir_tab[r].si, dir_tab[r].sq, gap, dir_tab[r].fixed, dir_tab[r].mean);
    end

    foreach (phase_win[p]) begin
      wl = (phase_win[p] == RAND_WIN) ? $urandom_range(1, 48) : phase_win[p];
      settle();
      cfg_write(ADDR_WINDOW_LEN, wl);
      eff = (wl == 0) ? 1 : (wl > MAX_WIN) ? MAX_WIN : wl;
      @(negedge clk);
      cfg_read_check(ADDR_WINDOW_LEN, eff);
      // refill the window, then a few dozen words past it; wide windows take
      // a partial fill with no word due
      n = (eff > FULL_MAX) ? $urandom_range(30, 50) : eff + $urandom_range(30, 50);
      for (int k = 0; k < n; k++) begin
        gap = draw_idle(tx_quiet);
        send_sample(rand_comp(), rand_comp(), gap, 1'b0, '0);
      end
    end

    settle();
    errors += mean_q.size();
    $display("%0d samples in, %0d mean words checked, %0d register writes", words_in,
             words_out, cfg_writes);
    $display("windows 1..64 run past full, 1024 and oversize clamp read back and part filled,");
    $display("zero length, unmapped index, long sink stall");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sink: random stall before every word, plus one long hold-off after word
  // HOLD_AT while the driver keeps offering, so the block backs up to in_stall.
  // ---------------------------------------------------------------------------
  initial begin : sink
    int hold;
    int got;
    got = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      hold = (got == HOLD_AT) ? HOLD_CYCLES : draw_idle(rx_quiet);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      got++;
      @(negedge clk);
    end
  end

  // Compare each taken word with the oldest owed mean.
  always @(posedge clk) begin : check_means
    logic [swea_pkg::OUT_W-1:0] want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      words_out++;
      if (mean_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected mean word: got %0d", out_mean_energy);
      end else begin
        want = mean_q.pop_front();
        if (out_mean_energy !== want) begin
          errors++;
          if (errors <= 10)
            $display("mean_energy mismatch: expected %0d got %0d", want, out_mean_energy);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
